// File: sv/link_quality_scorer_assert.svh
// Assertion macros used by the link quality scorer top level.
`ifndef LINK_QUALITY_SCORER_ASSERT_SVH
`define LINK_QUALITY_SCORER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LQS_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("link quality scorer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LQS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("link quality scorer: next-cycle check failed");

`endif

// File: sv/lqs_pkg.sv
// Shared types, constants and codes of the link quality scorer.
package lqs_pkg;

   // Field and register widths
   localparam int DEFAULT_LINK_SLOTS = 4;
   localparam int CNT_W      = 32;
   localparam int UID_W      = 32;
   localparam int MARK_W     = 32;
   localparam int OP_W       = 2;
   localparam int PERIOD_W   = 16;
   localparam int GAP_W      = 8;
   localparam int PCT_W      = 7;
   localparam int SCORE_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Socket mark decode
   localparam int MARK_SEL_W = 12;
   localparam logic [MARK_SEL_W-1:0] MARK_WIFI_TWO = 12'h200;
   localparam logic [MARK_SEL_W-1:0] MARK_CELLULAR = 12'h400;

   // Fixed link slots; background is the last slot
   localparam int SLOT_DEFAULT  = 0;
   localparam int SLOT_WIFI_TWO = 1;
   localparam int SLOT_CELLULAR = 2;

   // Scoring constants
   localparam logic signed [SCORE_W-1:0] NO_SCORE = 8'sd101;
   localparam int SCORE_MAX = 100;
   localparam int MOD_BASE  = 101;
   localparam int MIN_SEEN  = 10;

   // Remainder loop and bounded quotient divider
   localparam int MOD_STEPS = CNT_W;
   localparam int QUOT_W    = 7;
   localparam int DIV_STEPS = QUOT_W;
   localparam int NUM_W     = CNT_W + QUOT_W;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   // Smoothing: products, sum and divide by 100 through a reciprocal
   localparam int PROD_W      = 2 * SCORE_W;
   localparam int SUM_MAG_W   = 15;
   localparam int RECIP_C_W   = 13;
   localparam logic [RECIP_C_W-1:0] RECIP_100 = 13'd5243;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = SUM_MAG_W + RECIP_C_W;
   localparam int QUO_W       = RECIP_W - RECIP_SHIFT;

   // Register reset values
   localparam logic [UID_W-1:0]    RST_FOREGROUND_UID    = 32'd1;
   localparam logic [PERIOD_W-1:0] RST_RETRANSMIT_PERIOD = 16'd10;
   localparam logic [PERIOD_W-1:0] RST_NORMAL_PERIOD     = 16'd100;
   localparam logic [GAP_W-1:0]    RST_GAP_THRESHOLD     = 8'd5;
   localparam logic [PCT_W-1:0]    RST_SMOOTH_PERCENT    = 7'd20;
   localparam logic [PCT_W-1:0]    RST_PROTECT_LEVEL     = 7'd60;

   typedef enum logic [OP_W-1:0] {
      OP_NORMAL     = 2'd0,
      OP_RETRANSMIT = 2'd1,
      OP_UNDO       = 2'd2,
      OP_IGNORE     = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOREGROUND_UID    = 3'd0,
      CSR_RETRANSMIT_PERIOD = 3'd1,
      CSR_NORMAL_PERIOD     = 3'd2,
      CSR_GAP_THRESHOLD     = 3'd3,
      CSR_SMOOTH_PERCENT    = 3'd4,
      CSR_PROTECT_LEVEL     = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUMP,
      ST_MOD,
      ST_CHECK,
      ST_DIV_INIT,
      ST_DIV,
      ST_RAW,
      ST_SMOOTH_MUL,
      ST_SMOOTH_DIV,
      ST_FINISH,
      ST_DONE
   } lqs_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic bump;
      logic mod_step;
      logic score_setup;
      logic div_init;
      logic div_step;
      logic raw;
      logic smooth_mul;
      logic smooth_div;
      logic finish;
      logic load_out;
   } lqs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic eval_go;
      logic mod_zero;
      logic slot_default;
   } lqs_status_type;

endpackage

// File: sv/lqs_ctrl.sv
// Sequencer of the link quality scorer: state machine, step counter, output valid.
module lqs_ctrl
   import lqs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  lqs_status_type status,
   output lqs_cmd_type    cmd
);

   lqs_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // State, step counter and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_BUMP;
            end
         end
         ST_BUMP: begin
            cmd.bump = 1'b1;
            step_in  = '0;
            state_in = status.eval_go ? ST_MOD : ST_DONE;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MOD_STEPS - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.mod_zero) begin
               cmd.score_setup = 1'b1;
               state_in        = ST_DIV_INIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            cmd.raw  = 1'b1;
            state_in = status.slot_default ? ST_SMOOTH_MUL : ST_DONE;
         end
         ST_SMOOTH_MUL: begin
            cmd.smooth_mul = 1'b1;
            state_in       = ST_SMOOTH_DIV;
         end
         ST_SMOOTH_DIV: begin
            cmd.smooth_div = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/lqs_dpath.sv
// Datapath of the link quality scorer: registers, counters, remainder, divider, smoothing.
module lqs_dpath
   import lqs_pkg::*;
#(
   parameter int LINK_SLOTS = DEFAULT_LINK_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic [MARK_W-1:0]         req_socket_mark,
   input  logic [UID_W-1:0]          req_owner_uid,
   input  lqs_cmd_type               cmd,
   output lqs_status_type            status,
   output logic                      rsp_report_valid,
   output logic signed [SCORE_W-1:0] rsp_report_score,
   output logic signed [SCORE_W-1:0] rsp_wifi_two_score,
   output logic signed [SCORE_W-1:0] rsp_cellular_score,
   output logic signed [SCORE_W-1:0] rsp_background_link_score
);

   localparam int SLOT_W = $clog2(LINK_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_DEF = SLOT_W'(SLOT_DEFAULT);
   localparam logic [SLOT_W-1:0] SLOT_WF2 = SLOT_W'(SLOT_WIFI_TWO);
   localparam logic [SLOT_W-1:0] SLOT_CEL = SLOT_W'(SLOT_CELLULAR);
   localparam logic [SLOT_W-1:0] SLOT_BG  = SLOT_W'(LINK_SLOTS - 1);
   localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
   localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
   localparam logic signed [CNT_W:0]   SEEN_LIMIT = (CNT_W+1)'(MIN_SEEN);

   // Configuration registers
   logic [UID_W-1:0]    fg_uid_ff;
   logic [PERIOD_W-1:0] rtx_period_ff;
   logic [PERIOD_W-1:0] nrm_period_ff;
   logic [GAP_W-1:0]    gap_ff;
   logic [PCT_W-1:0]    smooth_ff;
   logic [PCT_W-1:0]    protect_ff;

   // Transaction and counter state
   opcode_type              op_ff;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic signed [CNT_W-1:0] nrm_cnt_ff [LINK_SLOTS];
   logic signed [CNT_W-1:0] rtx_cnt_ff [LINK_SLOTS];
   logic signed [CNT_W:0]   total_ff;
   logic signed [CNT_W-1:0] nrm_new_ff;

   // Remainder loop
   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] mod_rem_ff;
   logic [CNT_W-1:0]    mod_shift_ff;

   // Bounded divider
   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  dsh_ff;
   logic [CNT_W-1:0]  den_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic              neg_ff;
   logic              sat_ff;

   // Scores and smoothing
   logic signed [SCORE_W-1:0] raw_ff, raw_in;
   logic signed [SCORE_W-1:0] prev_ff;
   logic signed [SCORE_W-1:0] wifi_ff;
   logic signed [SCORE_W-1:0] cell_ff;
   logic signed [SCORE_W-1:0] bg_ff;
   logic signed [PROD_W-1:0]  prod_new_ff;
   logic signed [PROD_W-1:0]  prod_old_ff;
   logic [RECIP_W-1:0]        recip_ff;
   logic                      sum_neg_ff;
   logic                      res_valid_ff;
   logic signed [SCORE_W-1:0] res_score_ff;

   // Combinational helpers
   logic signed [CNT_W-1:0]   cur_nrm, cur_rtx, nrm_inc, nrm_dec, rtx_inc;
   logic signed [CNT_W-1:0]   nrm_new, rtx_new, cnt_hit;
   logic signed [CNT_W:0]     total_in;
   logic [PERIOD_W-1:0]       period_sel;
   logic [CNT_W-1:0]          cnt_mag, nrm_mag;
   logic [PERIOD_W:0]         mod_trial;
   logic [QUOT_W-1:0]         raw_mag;
   logic signed [SCORE_W-1:0] keep_pct, new_pct;
   logic signed [PROD_W:0]    sum_in;
   logic [PROD_W:0]           sum_abs;
   logic [QUO_W-1:0]          quo, raw_abs, pre_mag, mod_mag;
   logic                      pre_neg;
   logic [SCORE_W-1:0]        s_mag;
   logic signed [SCORE_W-1:0] s_in;
   logic signed [SCORE_W:0]   diff, prot;
   logic [SCORE_W:0]          diff_abs;
   logic                      gap_miss, protect_hit, report_in;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_uid_ff     <= RST_FOREGROUND_UID;
         rtx_period_ff <= RST_RETRANSMIT_PERIOD;
         nrm_period_ff <= RST_NORMAL_PERIOD;
         gap_ff        <= RST_GAP_THRESHOLD;
         smooth_ff     <= RST_SMOOTH_PERCENT;
         protect_ff    <= RST_PROTECT_LEVEL;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FOREGROUND_UID:    fg_uid_ff     <= csr_write_data[UID_W-1:0];
            CSR_RETRANSMIT_PERIOD: rtx_period_ff <= csr_write_data[PERIOD_W-1:0];
            CSR_NORMAL_PERIOD:     nrm_period_ff <= csr_write_data[PERIOD_W-1:0];
            CSR_GAP_THRESHOLD:     gap_ff        <= csr_write_data[GAP_W-1:0];
            CSR_SMOOTH_PERCENT:    smooth_ff     <= csr_write_data[PCT_W-1:0];
            CSR_PROTECT_LEVEL:     protect_ff    <= csr_write_data[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // Link slot from the socket mark and owner
   always_comb begin
      if (req_socket_mark[MARK_SEL_W-1:0] == MARK_WIFI_TWO) begin
         slot_in = SLOT_WF2;
      end else if (req_socket_mark[MARK_SEL_W-1:0] == MARK_CELLULAR) begin
         slot_in = SLOT_CEL;
      end else if (req_owner_uid != fg_uid_ff) begin
         slot_in = SLOT_BG;
      end else begin
         slot_in = SLOT_DEF;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= opcode_type'(req_opcode);
         slot_ff <= slot_in;
      end
   end

   // Counter update with saturation and evaluation qualifier
   assign cur_nrm  = nrm_cnt_ff[slot_ff];
   assign cur_rtx  = rtx_cnt_ff[slot_ff];
   assign total_in = {cur_rtx[CNT_W-1], cur_rtx} + {cur_nrm[CNT_W-1], cur_nrm};
   assign nrm_inc  = (cur_nrm == CNT_MAX) ? cur_nrm : cur_nrm + CNT_W'(1);
   assign nrm_dec  = (cur_nrm == CNT_MIN) ? cur_nrm : cur_nrm - CNT_W'(1);
   assign rtx_inc  = (cur_rtx == CNT_MAX) ? cur_rtx : cur_rtx + CNT_W'(1);

   always_comb begin
      nrm_new    = cur_nrm;
      rtx_new    = cur_rtx;
      cnt_hit    = nrm_inc;
      period_sel = '0;
      case (op_ff)
         OP_NORMAL: begin
            nrm_new    = nrm_inc;
            cnt_hit    = nrm_inc;
            period_sel = nrm_period_ff;
         end
         OP_RETRANSMIT: begin
            rtx_new    = rtx_inc;
            cnt_hit    = rtx_inc;
            period_sel = rtx_period_ff;
         end
         OP_UNDO: begin
            nrm_new = nrm_dec;
         end
         default: ;
      endcase
   end

   // zero period never evaluates; undo and ignore leave the period at zero
   assign status.eval_go = (period_sel != '0) && (total_in > SEEN_LIMIT);
   assign cnt_mag = cnt_hit[CNT_W-1] ? CNT_W'(-cnt_hit) : CNT_W'(cnt_hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINK_SLOTS; i++) begin
            nrm_cnt_ff[i] <= '0;
            rtx_cnt_ff[i] <= '0;
         end
      end else if (cmd.bump) begin
         nrm_cnt_ff[slot_ff] <= nrm_new;
         rtx_cnt_ff[slot_ff] <= rtx_new;
      end else if (cmd.finish) begin
         nrm_cnt_ff[SLOT_DEF] <= '0;
         rtx_cnt_ff[SLOT_DEF] <= '0;
      end
   end

   // Remainder of the bumped count by its period, one bit per cycle
   assign mod_trial       = {mod_rem_ff, mod_shift_ff[CNT_W-1]};
   assign status.mod_zero = (mod_rem_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.bump) begin
         total_ff     <= total_in;
         nrm_new_ff   <= nrm_new;
         period_ff    <= period_sel;
         mod_rem_ff   <= '0;
         mod_shift_ff <= cnt_mag;
      end else if (cmd.mod_step) begin
         if (mod_trial >= {1'b0, period_ff}) begin
            mod_rem_ff <= PERIOD_W'(mod_trial - {1'b0, period_ff});
         end else begin
            mod_rem_ff <= PERIOD_W'(mod_trial);
         end
         mod_shift_ff <= {mod_shift_ff[CNT_W-2:0], 1'b0};
      end
   end

   // Raw score 100*normal/(total+1); quotient only needs 7 bits before clamping
   assign nrm_mag = nrm_new_ff[CNT_W-1] ? CNT_W'(-nrm_new_ff) : CNT_W'(nrm_new_ff);

   always_ff @(posedge clock) begin
      if (cmd.score_setup) begin
         num_ff <= NUM_W'(nrm_mag) * NUM_W'(SCORE_MAX);
         neg_ff <= nrm_new_ff[CNT_W-1];
         den_ff <= total_ff[CNT_W-1:0] + CNT_W'(1);
      end else if (cmd.div_init) begin
         sat_ff  <= (num_ff >= {den_ff, {QUOT_W{1'b0}}});
         dsh_ff  <= {1'b0, den_ff, {(QUOT_W-1){1'b0}}};
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         if (num_ff >= dsh_ff) begin
            num_ff  <= num_ff - dsh_ff;
            quot_ff <= {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quot_ff <= {quot_ff[QUOT_W-2:0], 1'b0};
         end
         dsh_ff <= {1'b0, dsh_ff[NUM_W-1:1]};
      end
   end

   // Clamp to +/-100 and apply sign
   assign raw_mag = (sat_ff || quot_ff > QUOT_W'(SCORE_MAX)) ? QUOT_W'(SCORE_MAX) : quot_ff;
   assign raw_in  = neg_ff ? -SCORE_W'(raw_mag) : SCORE_W'(raw_mag);

   // Per-link stored scores
   always_ff @(posedge clock) begin
      if (reset) begin
         wifi_ff <= NO_SCORE;
         cell_ff <= NO_SCORE;
         bg_ff   <= NO_SCORE;
      end else if (cmd.raw) begin
         if (slot_ff == SLOT_WF2) begin
            wifi_ff <= raw_in;
         end else if (slot_ff == SLOT_CEL) begin
            cell_ff <= raw_in;
         end else if (slot_ff == SLOT_BG) begin
            bg_ff <= raw_in;
         end
      end
   end

   assign status.slot_default = (slot_ff == SLOT_DEF);

   // Smoothing against the last report
   assign keep_pct = $signed({1'b0, smooth_ff});
   assign new_pct  = $signed(SCORE_W'(SCORE_MAX)) - keep_pct;
   assign sum_in   = {prod_new_ff[PROD_W-1], prod_new_ff} + {prod_old_ff[PROD_W-1], prod_old_ff};
   assign sum_abs  = sum_in[PROD_W] ? (PROD_W+1)'(-sum_in) : (PROD_W+1)'(sum_in);

   always_ff @(posedge clock) begin
      if (cmd.raw) begin
         raw_ff <= raw_in;
      end
      if (cmd.smooth_mul) begin
         prod_new_ff <= raw_ff * new_pct;
         prod_old_ff <= prev_ff * keep_pct;
      end
      if (cmd.smooth_div) begin
         sum_neg_ff <= sum_in[PROD_W];
         recip_ff   <= RECIP_W'(sum_abs[SUM_MAG_W-1:0]) * RECIP_W'(RECIP_100);
      end
   end

   // Divide by 100 (raw score if no last report), remainder by 101, then gap and protect filters
   assign quo     = recip_ff[RECIP_W-1:RECIP_SHIFT];
   assign raw_abs = raw_ff[SCORE_W-1] ? QUO_W'(-raw_ff) : QUO_W'(raw_ff);
   assign pre_mag = (prev_ff != '0) ? quo : raw_abs;
   assign pre_neg = (prev_ff != '0) ? sum_neg_ff : raw_ff[SCORE_W-1];

   always_comb begin
      if (pre_mag >= QUO_W'(2 * MOD_BASE)) begin
         mod_mag = pre_mag - QUO_W'(2 * MOD_BASE);
      end else if (pre_mag >= QUO_W'(MOD_BASE)) begin
         mod_mag = pre_mag - QUO_W'(MOD_BASE);
      end else begin
         mod_mag = pre_mag;
      end
   end

   assign s_mag       = mod_mag[SCORE_W-1:0];
   assign s_in        = pre_neg ? -s_mag : s_mag;
   assign diff        = {s_in[SCORE_W-1], s_in} - {prev_ff[SCORE_W-1], prev_ff};
   assign diff_abs    = diff[SCORE_W] ? (SCORE_W+1)'(-diff) : (SCORE_W+1)'(diff);
   assign gap_miss    = diff_abs < {1'b0, gap_ff};
   assign prot        = $signed({2'b00, protect_ff});
   assign protect_hit = ($signed({s_in[SCORE_W-1], s_in}) < prot) &&
                        ($signed({prev_ff[SCORE_W-1], prev_ff}) < prot);
   assign report_in   = !gap_miss && !protect_hit;

   // Last report and pending result of the current transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (cmd.finish && report_in) begin
         prev_ff <= s_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_valid_ff <= 1'b0;
         res_score_ff <= '0;
      end else if (cmd.finish) begin
         res_valid_ff <= report_in;
         res_score_ff <= report_in ? s_in : '0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_report_valid          <= res_valid_ff;
         rsp_report_score          <= res_score_ff;
         rsp_wifi_two_score        <= wifi_ff;
         rsp_cellular_score        <= cell_ff;
         rsp_background_link_score <= bg_ff;
      end
   end

endmodule

// File: sv/link_quality_scorer.sv
// Top level of the link quality scorer: controller, datapath and checks.
// Each transaction is one TCP segment event counted in a link slot chosen from the
// socket mark (secondary wifi, cellular) and the owner uid (default or background).
// A transaction that does not evaluate goes from the bump state to the done state;
// one whose count is checked against its period adds the bit-serial remainder of
// the count by its period over all 32 count bits, a score for any slot
// adds the 7-step bounded divider, and a default-link report adds the smoothing
// pipeline of multiply, divide and finish steps. A finished
// result sits in an output register, so the next transaction is accepted while it
// waits. Configuration writes must only happen while no transaction is in flight.
`include "link_quality_scorer_assert.svh"

module link_quality_scorer
   import lqs_pkg::*;
#(
   parameter int LINK_SLOTS = DEFAULT_LINK_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic [MARK_W-1:0]         req_socket_mark,
   input  logic [UID_W-1:0]          req_owner_uid,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_report_valid,
   output logic signed [SCORE_W-1:0] rsp_report_score,
   output logic signed [SCORE_W-1:0] rsp_wifi_two_score,
   output logic signed [SCORE_W-1:0] rsp_cellular_score,
   output logic signed [SCORE_W-1:0] rsp_background_link_score,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   lqs_cmd_type    ctrl_cmd;
   lqs_status_type dp_status;

   lqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   lqs_dpath #(
      .LINK_SLOTS (LINK_SLOTS)
   ) u_dpath (
      .clock                     (clock),
      .reset                     (reset),
      .csr_write_en              (csr_write_en),
      .csr_index                 (csr_index),
      .csr_write_data            (csr_write_data),
      .req_opcode                (req_opcode),
      .req_socket_mark           (req_socket_mark),
      .req_owner_uid             (req_owner_uid),
      .cmd                       (ctrl_cmd),
      .status                    (dp_status),
      .rsp_report_valid          (rsp_report_valid),
      .rsp_report_score          (rsp_report_score),
      .rsp_wifi_two_score        (rsp_wifi_two_score),
      .rsp_cellular_score        (rsp_cellular_score),
      .rsp_background_link_score (rsp_background_link_score)
   );

   // busy right after a transaction is taken
   `LQS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // a pending result is never loaded over one that was not yet taken
   `LQS_ASSERT_SAME(a_no_overwrite, ctrl_cmd.load_out, !rsp_valid || rsp_ready)
   // counters are bumped only in the cycle after an accepted transaction
   `LQS_ASSERT_SAME(a_bump_follows_accept, ctrl_cmd.bump, $past(req_valid && req_ready))

endmodule

// File: tb/sv/link_quality_scorer_test.sv
// Self-checking testbench for the link quality scorer: directed and random segment traffic.
module link_quality_scorer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lqs_pkg::*;

   localparam int     CLOCK_PERIOD   = 4;
   localparam int     RESET_CYCLES   = 6;
   localparam int     BG_SLOT        = DEFAULT_LINK_SLOTS - 1;
   localparam int     PERCENT        = 100;
   localparam int     GAP_TOP        = 201;
   localparam int     PROTECT_TOP    = 101;
   localparam longint COUNT_TOP      = (longint'(1) <<< (CNT_W - 1)) - 1;
   localparam longint COUNT_BOTTOM   = -(longint'(1) <<< (CNT_W - 1));
   localparam int     PHASES         = 12;
   localparam int     PHASE_SEGMENTS = 150;
   localparam int     SETTLE_CYCLES  = 4;
   localparam int     DRAIN_CYCLES   = 60;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     REPORT_LIMIT   = 10;

   // One result transaction
   typedef struct {
      logic                      report_valid;
      logic signed [SCORE_W-1:0] report_score;
      logic signed [SCORE_W-1:0] wifi_two;
      logic signed [SCORE_W-1:0] cellular;
      logic signed [SCORE_W-1:0] background;
   } score_row_type;

   // Per-link segment counters, scores and the queue of results still to come
   class link_score_tracker_type;
      logic [UID_W-1:0]    fg_uid      = RST_FOREGROUND_UID;
      logic [PERIOD_W-1:0] rtx_period  = RST_RETRANSMIT_PERIOD;
      logic [PERIOD_W-1:0] norm_period = RST_NORMAL_PERIOD;
      logic [GAP_W-1:0]    gap_min     = RST_GAP_THRESHOLD;
      logic [PCT_W-1:0]    smooth_pct  = RST_SMOOTH_PERCENT;
      logic [PCT_W-1:0]    protect_lvl = RST_PROTECT_LEVEL;

      longint rtx_count[DEFAULT_LINK_SLOTS];
      longint normal_count[DEFAULT_LINK_SLOTS];
      longint last_report    = 0;
      longint wifi_two_val   = longint'(NO_SCORE);
      longint cellular_val   = longint'(NO_SCORE);
      longint background_val = longint'(NO_SCORE);

      score_row_type expected_scores[$];
      int unsigned   failures        = 0;
      int unsigned   results_checked = 0;
      int unsigned   reports         = 0;
      int unsigned   link_updates    = 0;

      function new();
         foreach (rtx_count[i]) begin
            rtx_count[i]    = 0;
            normal_count[i] = 0;
         end
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FOREGROUND_UID:    fg_uid      = data[UID_W-1:0];
            CSR_RETRANSMIT_PERIOD: rtx_period  = data[PERIOD_W-1:0];
            CSR_NORMAL_PERIOD:     norm_period = data[PERIOD_W-1:0];
            CSR_GAP_THRESHOLD:     gap_min     = data[GAP_W-1:0];
            CSR_SMOOTH_PERCENT:    smooth_pct  = data[PCT_W-1:0];
            CSR_PROTECT_LEVEL:     protect_lvl = data[PCT_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_count(longint v);
         if (v > COUNT_TOP) return COUNT_TOP;
         if (v < COUNT_BOTTOM) return COUNT_BOTTOM;
         return v;
      endfunction

      // a zero period never fires
      function bit on_period(longint count, longint period);
         if (period == 0) return 1'b0;
         return (count % period) == 0;
      endfunction

      // Count one accepted segment and queue the result it produces
      function void predict_scores(opcode_type op, logic [MARK_W-1:0] mark,
                                   logic [UID_W-1:0] uid);
         int            slot;
         longint        total, s, prev, diff;
         longint        sm, prot, gap, rtx_p, norm_p;
         bit            evaluate;
         score_row_type row;
         sm     = longint'(smooth_pct);
         prot   = longint'(protect_lvl);
         gap    = longint'(gap_min);
         rtx_p  = longint'(rtx_period);
         norm_p = longint'(norm_period);
         slot   = SLOT_DEFAULT;
         if (mark[MARK_SEL_W-1:0] == MARK_WIFI_TWO) slot = SLOT_WIFI_TWO;
         else if (mark[MARK_SEL_W-1:0] == MARK_CELLULAR) slot = SLOT_CELLULAR;
         if (slot == SLOT_DEFAULT && uid != fg_uid) slot = BG_SLOT;

         // total is taken before the bump, the score uses the bumped count
         total    = rtx_count[slot] + normal_count[slot];
         evaluate = 1'b0;
         case (op)
            OP_NORMAL: begin
               normal_count[slot] = clamp_count(normal_count[slot] + 1);
               evaluate = on_period(normal_count[slot], norm_p) && total > MIN_SEEN;
            end
            OP_RETRANSMIT: begin
               rtx_count[slot] = clamp_count(rtx_count[slot] + 1);
               evaluate = on_period(rtx_count[slot], rtx_p) && total > MIN_SEEN;
            end
            OP_UNDO: normal_count[slot] = clamp_count(normal_count[slot] - 1);
            default: ;
         endcase

         row.report_valid = 1'b0;
         row.report_score = '0;
         if (evaluate) begin
            s = (SCORE_MAX * normal_count[slot]) / (total + 1);
            if (s > SCORE_MAX) s = SCORE_MAX;
            if (s < -SCORE_MAX) s = -SCORE_MAX;
            if (slot == SLOT_DEFAULT) begin
               // smooth against last report, take the remainder by 101, then gap and protect hysteresis
               rtx_count[slot]    = 0;
               normal_count[slot] = 0;
               prev = last_report;
               if (prev != 0) s = (s * (PERCENT - sm) + prev * sm) / PERCENT;
               s    = s % MOD_BASE;
               diff = s - prev;
               if (diff < 0) diff = -diff;
               if (diff >= gap && !(s < prot && prev < prot)) begin
                  last_report      = s;
                  row.report_valid = 1'b1;
                  row.report_score = s[SCORE_W-1:0];
                  reports++;
               end
            end else begin
               if (slot == SLOT_WIFI_TWO) wifi_two_val = s;
               else if (slot == SLOT_CELLULAR) cellular_val = s;
               else background_val = s;
               link_updates++;
            end
         end
         row.wifi_two   = wifi_two_val[SCORE_W-1:0];
         row.cellular   = cellular_val[SCORE_W-1:0];
         row.background = background_val[SCORE_W-1:0];
         expected_scores.push_back(row);
      endfunction

      // Compare one result transaction with the oldest expectation
      function void check_scores(score_row_type seen);
         score_row_type want;
         results_checked++;
         if (expected_scores.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("[%0t] unexpected result: report %0b/%0d wifi2 %0d cell %0d bg %0d",
                        $time, seen.report_valid, seen.report_score, seen.wifi_two,
                        seen.cellular, seen.background);
            return;
         end
         want = expected_scores.pop_front();
         if (seen.report_valid !== want.report_valid || seen.report_score !== want.report_score ||
             seen.wifi_two !== want.wifi_two || seen.cellular !== want.cellular ||
             seen.background !== want.background) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("[%0t] result %0d expected: report %0b/%0d wifi2 %0d cell %0d bg %0d",
                        $time, results_checked, want.report_valid, want.report_score,
                        want.wifi_two, want.cellular, want.background);
               $display("[%0t] result %0d actual:   report %0b/%0d wifi2 %0d cell %0d bg %0d",
                        $time, results_checked, seen.report_valid, seen.report_score,
                        seen.wifi_two, seen.cellular, seen.background);
            end
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_opcode = OP_IGNORE;
   logic [MARK_W-1:0]         req_socket_mark = '0;
   logic [UID_W-1:0]          req_owner_uid = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b1;
   logic                      rsp_report_valid;
   logic signed [SCORE_W-1:0] rsp_report_score;
   logic signed [SCORE_W-1:0] rsp_wifi_two_score;
   logic signed [SCORE_W-1:0] rsp_cellular_score;
   logic signed [SCORE_W-1:0] rsp_background_link_score;
   logic                      csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_FOREGROUND_UID;
   logic [CSR_DATA_W-1:0]     csr_write_data = '0;

   link_score_tracker_type tracker = new();
   logic [UID_W-1:0]       fg_uid_now = RST_FOREGROUND_UID;
   bit                     req_gaps = 1'b0;
   bit                     rsp_stalls = 1'b0;
   bit                     quiet_tail = 1'b0;
   int unsigned            rsp_hold = 0;
   int unsigned            quiet_cycles = 0;
   int unsigned            sent_segments = 0;
   score_row_type          seen_row;

   link_quality_scorer #(.LINK_SLOTS(DEFAULT_LINK_SLOTS)) DUT (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Result side back-pressure: random stalls on rsp_ready
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         if (rsp_hold == 1) rsp_ready <= 1'b1;
      end else if (rsp_stalls && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= $urandom_range(1, 3);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_row.report_valid = rsp_report_valid;
         seen_row.report_score = rsp_report_score;
         seen_row.wifi_two     = rsp_wifi_two_score;
         seen_row.cellular     = rsp_cellular_score;
         seen_row.background   = rsp_background_link_score;
         tracker.check_scores(seen_row);
      end
   end

   // Watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [MARK_W-1:0] mark_for(input int slot);
      logic [MARK_W-1:0] mark;
      mark = $urandom();
      if (slot == SLOT_WIFI_TWO) mark[MARK_SEL_W-1:0] = MARK_WIFI_TWO;
      else if (slot == SLOT_CELLULAR) mark[MARK_SEL_W-1:0] = MARK_CELLULAR;
      else if (mark[MARK_SEL_W-1:0] == MARK_WIFI_TWO || mark[MARK_SEL_W-1:0] == MARK_CELLULAR)
         mark[0] = 1'b1;
      return mark;
   endfunction

   // secondary links get the foreground uid about half the time
   function automatic logic [UID_W-1:0] uid_for(input int slot);
      logic [UID_W-1:0] uid;
      uid = $urandom();
      if (slot == SLOT_DEFAULT || (slot != BG_SLOT && uid[0])) uid = fg_uid_now;
      else if (slot == BG_SLOT && uid == fg_uid_now) uid = ~uid;
      return uid;
   endfunction

   // Present one segment transaction and hold it until accepted
   task automatic send_segment(input opcode_type op, input logic [MARK_W-1:0] mark,
                               input logic [UID_W-1:0] uid);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_socket_mark <= mark;
      req_owner_uid   <= uid;
      do @(posedge clock); while (!req_ready);
      tracker.predict_scores(op, mark, uid);
      sent_segments++;
   endtask

   // Register write; bits above the register width are random
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value,
                            input int width);
      logic [CSR_DATA_W-1:0] keep;
      logic [CSR_DATA_W-1:0] data;
      keep = (width >= CSR_DATA_W) ? '1 : ((CSR_DATA_W'(1) << width) - 1'b1);
      data = ($urandom() & ~keep) | (value & keep);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      tracker.set_register(idx, data);
   endtask

   // Wait until every expected result is back and the block is idle
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.expected_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input int phase);
      logic [UID_W-1:0]    uid_set;
      logic [PERIOD_W-1:0] rtx_set, norm_set;
      logic [GAP_W-1:0]    gap_set;
      logic [PCT_W-1:0]    smooth_set, protect_set;
      uid_set     = $urandom();
      rtx_set     = PERIOD_W'($urandom_range(1, 12));
      norm_set    = PERIOD_W'($urandom_range(1, 24));
      gap_set     = GAP_W'($urandom_range(0, 12));
      smooth_set  = PCT_W'($urandom_range(0, PERCENT));
      protect_set = PCT_W'($urandom_range(0, PROTECT_TOP));
      case (phase)
         0: begin // low corners, every count is on its period
            uid_set     = '0;
            rtx_set     = PERIOD_W'(1);
            norm_set    = PERIOD_W'(1);
            gap_set     = '0;
            smooth_set  = '0;
            protect_set = '0;
         end
         1: begin // high corners; no report can clear the gap
            uid_set     = '1;
            rtx_set     = '1;
            gap_set     = GAP_W'(GAP_TOP);
            smooth_set  = PCT_W'(PERCENT);
            protect_set = PCT_W'(PROTECT_TOP);
         end
         2: begin // zero periods never evaluate
            rtx_set  = '0;
            norm_set = '0;
         end
         4: begin // full smoothing, no gap; a negative score after a negative report is still held back
            gap_set     = '0;
            smooth_set  = PCT_W'(PERCENT);
            protect_set = '0;
         end
         7: begin // no smoothing, protect blocks everything below 101
            smooth_set  = '0;
            protect_set = PCT_W'(PROTECT_TOP);
         end
         default: ;
      endcase
      write_reg(CSR_FOREGROUND_UID, uid_set, UID_W);
      write_reg(CSR_RETRANSMIT_PERIOD, CSR_DATA_W'(rtx_set), PERIOD_W);
      write_reg(CSR_NORMAL_PERIOD, CSR_DATA_W'(norm_set), PERIOD_W);
      write_reg(CSR_GAP_THRESHOLD, CSR_DATA_W'(gap_set), GAP_W);
      write_reg(CSR_SMOOTH_PERCENT, CSR_DATA_W'(smooth_set), PCT_W);
      write_reg(CSR_PROTECT_LEVEL, CSR_DATA_W'(protect_set), PCT_W);
      csr_write_en <= 1'b0;
      fg_uid_now = uid_set;
   endtask

   // One burst of random traffic
   task automatic traffic_burst();
      int         kind, slot, roll;
      opcode_type op;
      kind = $urandom_range(0, 9);
      roll = $urandom_range(0, 9);
      if (roll < 4) slot = SLOT_DEFAULT;
      else if (roll < 6) slot = SLOT_WIFI_TWO;
      else if (roll < 8) slot = SLOT_CELLULAR;
      else slot = BG_SLOT;
      req_gaps   = !quiet_tail && ($urandom_range(0, 2) != 0);
      rsp_stalls = !quiet_tail && ($urandom_range(0, 2) != 0);
      if (kind < 6) begin
         // steady traffic on one link with a mix of events
         repeat ($urandom_range(8, 40)) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) op = OP_NORMAL;
            else if (roll < 80) op = OP_RETRANSMIT;
            else if (roll < 93) op = OP_UNDO;
            else op = OP_IGNORE;
            send_segment(op, mark_for(slot), uid_for(slot));
         end
      end else if (kind < 8) begin
         // undo run, then retransmits: drives the link score negative
         repeat ($urandom_range(10, 16)) send_segment(OP_UNDO, mark_for(slot), uid_for(slot));
         repeat ($urandom_range(20, 36))
            send_segment(OP_RETRANSMIT, mark_for(slot), uid_for(slot));
      end else begin
         // noise: unconstrained fields, ignored opcode included
         repeat ($urandom_range(4, 12))
            send_segment(opcode_type'($urandom_range(0, 3)), $urandom(), $urandom());
      end
   endtask

   initial begin
      int unsigned target;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, ignored and undo events under reset settings
      send_segment(OP_IGNORE, '0, '0);
      send_segment(OP_IGNORE, '1, '1);
      send_segment(OP_UNDO, '0, RST_FOREGROUND_UID);
      send_segment(OP_NORMAL, {20'hFFFFF, MARK_WIFI_TWO}, '0);
      send_segment(OP_RETRANSMIT, {20'hFFFFF, MARK_CELLULAR}, '1);
      send_segment(OP_NORMAL, '1, RST_FOREGROUND_UID);
      send_segment(OP_UNDO, {20'h00000, MARK_WIFI_TWO}, RST_FOREGROUND_UID);
      send_segment(OP_RETRANSMIT, 32'h8000_0000, 32'h7FFF_FFFF);
      settle();
      write_reg(CSR_RETRANSMIT_PERIOD, CSR_DATA_W'(1), PERIOD_W);
      csr_write_en <= 1'b0;
      // first default-link report: eleven sends, then a retransmit evaluates
      repeat (11) send_segment(OP_NORMAL, mark_for(SLOT_DEFAULT), fg_uid_now);
      send_segment(OP_RETRANSMIT, mark_for(SLOT_DEFAULT), fg_uid_now);

      // Random phases, each under its own register settings
      for (int p = 0; p < PHASES; p++) begin
         settle();
         apply_settings(p);
         quiet_tail = (p == PHASES - 1);
         target = sent_segments + PHASE_SEGMENTS;
         while (sent_segments < target) traffic_burst();
      end
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d segment transactions under %0d register settings, %0d results checked.",
               sent_segments, PHASES + 2, tracker.results_checked);
      $display("Default-link reports: %0d, other link score updates: %0d, failures: %0d.",
               tracker.reports, tracker.link_updates, tracker.failures);
      if (tracker.failures == 0 && tracker.expected_scores.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
